// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of the decoder.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define H6D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("h6d check failed in the same cycle");

// Check cons in the cycle after ante, outside reset.
`define H6D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("h6d check failed one cycle later");

// Check cons in the cycle after reset is applied.
`define H6D_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("h6d check failed after reset");

`endif

// ===== hdl/h6d_pkg.sv =====
// Shared types, constants and codes of the HAM6 planar decoder.
// No dependencies; all files but h6d_ram and the macros import it.
package h6d_pkg;

  localparam int unsigned PIX_PER_WORD = 8;
  localparam int unsigned RGB_W        = 12;
  localparam int unsigned NIB_W        = 4;
  localparam int unsigned CTRL_W       = 2;
  localparam int unsigned PAL_DEPTH    = 16;
  localparam int unsigned PAL_IDX_W    = $clog2(PAL_DEPTH);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RGB_W-1:0] RGB_MASK = 12'h0FFF;
  localparam logic [RGB_W-1:0] KEEP_RG  = 12'h0FF0;
  localparam logic [RGB_W-1:0] KEEP_GB  = 12'h00FF;
  localparam logic [RGB_W-1:0] KEEP_RB  = 12'h0F0F;

  typedef logic [RGB_W-1:0]  rgb_t;
  typedef logic [NIB_W-1:0]  nib_t;
  typedef logic [CTRL_W-1:0] ctl_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [CTRL_W-1:0] {
    CTRL_PALETTE = 2'd0,
    CTRL_BLUE    = 2'd1,
    CTRL_RED     = 2'd2,
    CTRL_GREEN   = 2'd3
  } ctrl_t;

  typedef struct packed {
    logic                         row_start;
    rgb_t                         pal0;
    nib_t [PIX_PER_WORD-1:0]      data;
    ctl_t [PIX_PER_WORD-1:0]      ctrl;
    rgb_t [PIX_PER_WORD-1:0]      lut;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/h6d_in_if.sv =====
// Input channel of the decoder: valid/ready handshake plus one input word.
// Depends on h6d_pkg.
interface h6d_in_if;
  import h6d_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [PAL_IDX_W-1:0] palette_index;
  logic [RGB_W-1:0]     palette_value;
  logic                 row_start;
  logic [7:0]           plane_bits_0;
  logic [7:0]           plane_bits_1;
  logic [7:0]           plane_bits_2;
  logic [7:0]           plane_bits_3;
  logic [7:0]           plane_bits_4;
  logic [7:0]           plane_bits_5;

  modport source (
    output valid, op, palette_index, palette_value, row_start,
           plane_bits_0, plane_bits_1, plane_bits_2,
           plane_bits_3, plane_bits_4, plane_bits_5,
    input  ready
  );

  modport sink (
    input  valid, op, palette_index, palette_value, row_start,
           plane_bits_0, plane_bits_1, plane_bits_2,
           plane_bits_3, plane_bits_4, plane_bits_5,
    output ready
  );
endinterface

// ===== hdl/h6d_out_if.sv =====
// Result channel of the decoder: valid/ready handshake plus eight RGB pixels.
// Depends on h6d_pkg.
interface h6d_out_if;
  import h6d_pkg::*;

  logic valid;
  logic ready;
  rgb_t rgb_0;
  rgb_t rgb_1;
  rgb_t rgb_2;
  rgb_t rgb_3;
  rgb_t rgb_4;
  rgb_t rgb_5;
  rgb_t rgb_6;
  rgb_t rgb_7;

  modport source (
    output valid, rgb_0, rgb_1, rgb_2, rgb_3, rgb_4, rgb_5, rgb_6, rgb_7,
    input  ready
  );

  modport sink (
    input  valid, rgb_0, rgb_1, rgb_2, rgb_3, rgb_4, rgb_5, rgb_6, rgb_7,
    output ready
  );
endinterface

// ===== hdl/ham6_planar_decoder_top.sv =====
// Top level of the HAM6 planar decoder: front stage, group queue, back stage.
// Depends on h6d_pkg, h6d_in_if, h6d_out_if, h6d_front, h6d_queue, h6d_back.
//
// The decoder takes one input word per cycle, sustained, as long as results
// are taken. A palette-load word writes one of sixteen 12-bit entries and
// gives no result; a pixel word gives one word of eight 12-bit RGB pixels,
// which passes the front register with the palette read (loaded at the
// accepting edge), one queue slot and the output register. Every lane has
// its own copy of the palette RAM, read once per group, and the eight-pixel
// hold chain is combinational in the back stage; these set the rate of one
// group per cycle while results are taken.
// A two-entry queue lets the input keep flowing for a short while when the
// result side stalls. Reading a palette entry never written since reset
// gives an undefined colour.
module ham6_planar_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  h6d_in_if.sink    in_chan,
  h6d_out_if.source out_chan
);
  import h6d_pkg::*;

  group_t  f_grp;
  group_t  q_grp;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  h6d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .push    (push),
    .grp     (f_grp)
  );

  h6d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (f_grp),
    .pop       (pop),
    .pop_data  (q_grp),
    .stat      (q_stat)
  );

  h6d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp      (q_grp),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ===== hdl/h6d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module h6d_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/h6d_front.sv =====
// Front stage: accepts input words, loads the palette, splits pixel words
// into lanes and looks up each lane's palette entry. Depends on h6d_pkg,
// h6d_in_if and h6d_ram.
module h6d_front (
  input  logic             clk,
  input  logic             rst_n,
  h6d_in_if.sink           in_chan,
  input  h6d_pkg::q_stat_t q_stat,
  output logic             push,
  output h6d_pkg::group_t  grp
);
  import h6d_pkg::*;

  logic advance;
  logic acc;
  logic load_we;
  logic pix_acc;
  logic f_valid_r;
  logic f_valid_nxt;
  logic row_start_r;
  rgb_t pal0_r;
  rgb_t pal0_snap_r;
  rgb_t wr_value;
  nib_t [PIX_PER_WORD-1:0] lane_nib;
  ctl_t [PIX_PER_WORD-1:0] lane_ctrl;
  rgb_t [PIX_PER_WORD-1:0] lane_lut;
  nib_t [PIX_PER_WORD-1:0] data_r;
  ctl_t [PIX_PER_WORD-1:0] ctrl_r;

  assign advance       = !f_valid_r || !q_stat.full;
  assign in_chan.ready = advance;
  assign acc           = in_chan.valid && advance;
  assign load_we       = acc && (in_chan.op == OP_LOAD);
  assign pix_acc       = acc && (in_chan.op == OP_PIXEL);
  assign wr_value      = in_chan.palette_value & RGB_MASK;

  for (genvar k = 0; k < PIX_PER_WORD; k++) begin : g_lane
    localparam int unsigned B = PIX_PER_WORD - 1 - k;

    assign lane_nib[k]  = {in_chan.plane_bits_3[B], in_chan.plane_bits_2[B],
                           in_chan.plane_bits_1[B], in_chan.plane_bits_0[B]};
    assign lane_ctrl[k] = {in_chan.plane_bits_5[B], in_chan.plane_bits_4[B]};

    h6d_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_DEPTH)
    ) u_pal (
      .clk   (clk),
      .we    (load_we),
      .waddr (in_chan.palette_index),
      .wdata (wr_value),
      .re    (pix_acc),
      .raddr (lane_nib[k]),
      .rdata (lane_lut[k])
    );
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (advance) begin
      f_valid_nxt = pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      data_r      <= lane_nib;
      ctrl_r      <= lane_ctrl;
      row_start_r <= in_chan.row_start;
      pal0_snap_r <= pal0_r;
    end
    if (load_we && (in_chan.palette_index == '0)) begin
      pal0_r <= wr_value;
    end
  end

  assign push = f_valid_r && !q_stat.full;
  assign grp  = '{row_start: row_start_r, pal0: pal0_snap_r, data: data_r,
                  ctrl: ctrl_r, lut: lane_lut};

endmodule

// ===== hdl/h6d_queue.sv =====
// Short queue of classified pixel groups between front and back stages.
// Depends on h6d_pkg.
module h6d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  h6d_pkg::group_t  push_data,
  input  logic             pop,
  output h6d_pkg::group_t  pop_data,
  output h6d_pkg::q_stat_t stat
);
  import h6d_pkg::*;

  group_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r;
  logic [QUEUE_CW-1:0]   count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_r + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_r + QUEUE_AW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QUEUE_CW'(1);
      2'b01:   count_nxt = count_r - QUEUE_CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ===== hdl/h6d_back.sv =====
// Back stage: runs the hold-and-modify chain over one group and holds the
// result word for the output channel. Depends on h6d_pkg and h6d_out_if.
module h6d_back (
  input  logic             clk,
  input  logic             rst_n,
  input  h6d_pkg::group_t  grp,
  input  h6d_pkg::q_stat_t q_stat,
  output logic             pop,
  h6d_out_if.source        out_chan
);
  import h6d_pkg::*;

  function automatic rgb_t ham_step(input rgb_t held, input ctl_t ctrl,
                                    input nib_t data, input rgb_t lut);
    rgb_t c;
    unique case (ctrl_t'(ctrl))
      CTRL_PALETTE: c = lut;
      CTRL_BLUE:    c = (held & KEEP_RG) | {8'h00, data};
      CTRL_RED:     c = (held & KEEP_GB) | {data, 8'h00};
      CTRL_GREEN:   c = (held & KEEP_RB) | {4'h0, data, 4'h0};
    endcase
    return c & RGB_MASK;
  endfunction

  logic take;
  logic out_valid_r;
  logic out_valid_nxt;
  rgb_t held_r;
  rgb_t held_nxt;
  rgb_t [PIX_PER_WORD-1:0] pix;
  rgb_t [PIX_PER_WORD-1:0] rgb_r;

  assign take = !q_stat.empty && (!out_valid_r || out_chan.ready);
  assign pop  = take;

  always_comb begin
    rgb_t held;
    held = grp.row_start ? grp.pal0 : held_r;
    for (int k = 0; k < PIX_PER_WORD; k++) begin
      pix[k] = ham_step(held, grp.ctrl[k], grp.data[k], grp.lut[k]);
      held   = pix[k];
    end
  end

  always_comb begin
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      held_nxt      = pix[PIX_PER_WORD-1];
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rgb_r <= pix;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.rgb_0 = rgb_r[0];
  assign out_chan.rgb_1 = rgb_r[1];
  assign out_chan.rgb_2 = rgb_r[2];
  assign out_chan.rgb_3 = rgb_r[3];
  assign out_chan.rgb_4 = rgb_r[4];
  assign out_chan.rgb_5 = rgb_r[5];
  assign out_chan.rgb_6 = rgb_r[6];
  assign out_chan.rgb_7 = rgb_r[7];

endmodule

// ===== hdl/h6d_checker.sv =====
// Port-level checker of the decoder and its bind to the top level.
// Depends on h6d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module h6d_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input h6d_pkg::rgb_t [h6d_pkg::PIX_PER_WORD-1:0] out_rgb
);
  import h6d_pkg::*;

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `H6D_ASSERT_RESET(a_reset_clears_out, clk, rst_n, !out_valid)

  `H6D_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_stall, out_valid)

  `H6D_ASSERT_NEXT(a_out_word_holds, clk, rst_n, out_stall, $stable(out_rgb))

  `H6D_ASSERT_NOW(a_in_stall_from_out, clk, rst_n, !in_ready, out_valid && $past(out_stall))

endmodule

bind ham6_planar_decoder_top h6d_checker u_h6d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_rgb   ({out_chan.rgb_7, out_chan.rgb_6, out_chan.rgb_5, out_chan.rgb_4,
                out_chan.rgb_3, out_chan.rgb_2, out_chan.rgb_1, out_chan.rgb_0})
);
